[rtl/two_level_cache_critical_word_first_macros.svh]
// Assertion helpers shared by the cache block.
`ifndef TWO_LEVEL_CACHE_CRITICAL_WORD_FIRST_MACROS_SVH
`define TWO_LEVEL_CACHE_CRITICAL_WORD_FIRST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tlc_pkg.sv]
package tlc_pkg;

  // Geometry
  localparam int NEAR_LINES  = 4;
  localparam int FAR_LINES   = 16;
  localparam int BLOCK_WORDS = 4;
  localparam int STORE_BYTES = 128;

  localparam int ADDR_W   = 7;
  localparam int DATA_W   = 8;
  localparam int OFF_W    = $clog2(BLOCK_WORDS);
  localparam int NI_W     = $clog2(NEAR_LINES);
  localparam int FI_W     = $clog2(FAR_LINES);
  localparam int STORE_AW = $clog2(STORE_BYTES);
  localparam int LINE_W   = ADDR_W - OFF_W;
  localparam int NTAG_W   = ADDR_W - OFF_W - NI_W;
  localparam int FTAG_W   = ADDR_W - OFF_W - FI_W;
  localparam int CNT_W    = OFF_W;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    SRC_L1  = 2'd0,
    SRC_L2  = 2'd1,
    SRC_MEM = 2'd2
  } src_e;

  typedef logic [BLOCK_WORDS-1:0][DATA_W-1:0] block_t;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] load_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [OFF_W-1:0]  word_offset;
    logic [1:0]        source;
    logic              last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic             capture;
    logic             store_wr;
    logic             load_near;
    logic             load_far;
    logic             take_src;
    src_e             src;
    logic             fetch;
    logic             commit_near;
    logic             commit_far;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic near_hit;
    logic far_hit;
  } sts_t;

endpackage

[rtl/tlc_ctrl.sv]
module tlc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_func_i,
  input  logic          out_stall_i,
  input  tlc_pkg::sts_t sts_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output tlc_pkg::cmd_t cmd_o
);
  import tlc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH,
    ST_FWAIT,
    ST_COMMIT,
    ST_EMIT
  } state_e;

  localparam logic [CNT_W-1:0] CntLast = CNT_W'(BLOCK_WORDS - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             from_mem_q, from_mem_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    from_mem_d  = from_mem_q;
    cmd_o       = '0;
    cmd_o.cnt   = cnt_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_func_i == FUNC_READ) begin
            state_d = ST_LOOKUP;
          end else begin
            cmd_o.store_wr = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
        cmd_o.take_src = 1'b1;
        cnt_d          = '0;
        if (sts_i.near_hit) begin
          cmd_o.load_near = 1'b1;
          cmd_o.src       = SRC_L1;
          state_d         = ST_EMIT;
        end else if (sts_i.far_hit) begin
          cmd_o.load_far = 1'b1;
          cmd_o.src      = SRC_L2;
          from_mem_d     = 1'b0;
          state_d        = ST_COMMIT;
        end else begin
          cmd_o.src  = SRC_MEM;
          from_mem_d = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // one store byte read per cycle
        cmd_o.fetch = 1'b1;
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          state_d = ST_FWAIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FWAIT: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit_near = 1'b1;
        cmd_o.commit_far  = from_mem_q;
        cnt_d             = '0;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (cnt_q == CntLast) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      from_mem_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      from_mem_q <= from_mem_d;
    end
  end

endmodule

[rtl/tlc_dpath.sv]
module tlc_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tlc_pkg::req_t in_data_i,
  input  tlc_pkg::cmd_t cmd_i,
  output tlc_pkg::sts_t sts_o,
  output tlc_pkg::res_t out_data_o
);
  import tlc_pkg::*;

  // Cache arrays and backing store
  logic [NEAR_LINES-1:0]          near_vld_q;
  logic [NEAR_LINES-1:0][NTAG_W-1:0] near_tag_q;
  block_t                         near_blk_q [NEAR_LINES];
  logic [FAR_LINES-1:0]           far_vld_q;
  logic [FAR_LINES-1:0][FTAG_W-1:0]  far_tag_q;
  block_t                         far_blk_q [FAR_LINES];
  logic [DATA_W-1:0]              store_mem [STORE_BYTES];

  logic [ADDR_W-1:0] addr_q;
  block_t            buf_q;
  src_e              src_q;
  logic [DATA_W-1:0] rd_data_q;
  logic [CNT_W-1:0]  fill_idx_q;
  logic              fill_vld_q;

  logic [OFF_W-1:0]    off;
  logic [NI_W-1:0]     ni;
  logic [FI_W-1:0]     fi;
  logic [NTAG_W-1:0]   ntag;
  logic [FTAG_W-1:0]   ftag;
  logic [ADDR_W-1:0]   fetch_addr;
  logic [OFF_W-1:0]    rot_base;
  logic [OFF_W-1:0]    rd_idx;

  // Address split
  assign off  = addr_q[OFF_W-1:0];
  assign ni   = addr_q[OFF_W +: NI_W];
  assign fi   = addr_q[OFF_W +: FI_W];
  assign ntag = addr_q[ADDR_W-1 -: NTAG_W];
  assign ftag = addr_q[ADDR_W-1 -: FTAG_W];

  assign sts_o.near_hit = near_vld_q[ni] && (near_tag_q[ni] == ntag);
  assign sts_o.far_hit  = far_vld_q[fi] && (far_tag_q[fi] == ftag);

  // Block-aligned fetch address, wraps in the store
  assign fetch_addr = {addr_q[ADDR_W-1:OFF_W], cmd_i.cnt};

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= in_data_i.address;
    end
    if (cmd_i.take_src) begin
      src_q <= cmd_i.src;
    end
  end

  // Backing store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      store_mem[in_data_i.address[STORE_AW-1:0]] <= in_data_i.load_value;
    end
    if (cmd_i.fetch) begin
      rd_data_q  <= store_mem[fetch_addr[STORE_AW-1:0]];
      fill_idx_q <= cmd_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q <= 1'b0;
    end else begin
      fill_vld_q <= cmd_i.fetch;
    end
  end

  // Line buffer: loaded from a cache line or filled byte by byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_near) begin
      buf_q <= near_blk_q[ni];
    end else if (cmd_i.load_far) begin
      buf_q <= far_blk_q[fi];
    end else if (fill_vld_q) begin
      buf_q[fill_idx_q] <= rd_data_q;
    end
  end

  // Line writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_near) begin
      near_blk_q[ni] <= buf_q;
      near_tag_q[ni] <= ntag;
    end
    if (cmd_i.commit_far) begin
      far_blk_q[fi] <= buf_q;
      far_tag_q[fi] <= ftag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_vld_q <= '0;
      far_vld_q  <= '0;
    end else begin
      if (cmd_i.commit_near) begin
        near_vld_q[ni] <= 1'b1;
      end
      if (cmd_i.commit_far) begin
        far_vld_q[fi] <= 1'b1;
      end
    end
  end

  // Result beat: fills and L2 hits start at the requested word, L1 hits at word zero
  assign rot_base = (src_q == SRC_L1) ? '0 : off;
  assign rd_idx   = rot_base + cmd_i.cnt;

  assign out_data_o.word        = buf_q[rd_idx];
  assign out_data_o.word_offset = rd_idx;
  assign out_data_o.source      = src_q;
  assign out_data_o.last        = (cmd_i.cnt == CNT_W'(BLOCK_WORDS - 1));

endmodule

[rtl/two_level_cache_critical_word_first.sv]
// Load beat: written to the store when accepted, no result; next item may follow at once.
// Read beat: an L1 hit goes from lookup straight to the result beats, one per cycle
// while the output does not stall; an L2 hit adds the L1 line write, a miss adds
// four store reads through the single registered port, a drain state and the line write.
// One read in flight: no new request is taken until the last result beat leaves.
// Reset clears all valid bits and the controller; store contents are undefined.
module two_level_cache_critical_word_first (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tlc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tlc_pkg::res_t out_data_o
);
  import tlc_pkg::*;

`include "two_level_cache_critical_word_first_macros.svh"

  cmd_t cmd;
  sts_t sts;

  tlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  tlc_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // Checks
  `TLC_ASSERT_NOW(a_emit_blocks_input, out_valid_o, in_stall_o, "input open while emitting")
  `TLC_ASSERT_NEXT(a_last_ends_read, out_valid_o && !out_stall_i && out_data_o.last, !out_valid_o, "beat after last")
  `TLC_ASSERT_NEXT(a_read_busy, in_valid_i && !in_stall_o && in_data_i.func == FUNC_READ, in_stall_o, "read not held")
  `TLC_ASSERT_NEXT(a_load_one_cycle, in_valid_i && !in_stall_o && in_data_i.func == FUNC_LOAD, !in_stall_o, "load stalled")

endmodule

[dv/tlc_read_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the cache, keeps a shadow of L1, L2 and the store,
// and checks every returned beat against the predicted word stream.
module tlc_read_checker
  import tlc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  req_t in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  res_t out_data_i,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o
);

  // Shadow cache and store
  logic [NEAR_LINES-1:0] l1_valid;
  logic [NTAG_W-1:0]     l1_tag  [NEAR_LINES];
  block_t                l1_data [NEAR_LINES];
  logic [FAR_LINES-1:0]  l2_valid;
  logic [FTAG_W-1:0]     l2_tag  [FAR_LINES];
  block_t                l2_data [FAR_LINES];
  logic [DATA_W-1:0]     store   [STORE_BYTES];

  // Beats still owed by the block, oldest first
  res_t read_beats_q[$];

  // Look up one read, update the shadow lines and queue its four beats
  task automatic predict_read(input logic [ADDR_W-1:0] addr);
    int     blk_no;
    int     first;
    int     ni;
    int     fi;
    int     w;
    logic [NTAG_W-1:0] nt;
    logic [FTAG_W-1:0] ft;
    src_e   src;
    block_t data;
    res_t   beat;
    blk_no = (int'(addr) % STORE_BYTES) / BLOCK_WORDS;
    first  = (int'(addr) % STORE_BYTES) % BLOCK_WORDS;
    ni     = blk_no % NEAR_LINES;
    fi     = blk_no % FAR_LINES;
    nt     = NTAG_W'((int'(addr) % STORE_BYTES) / (NEAR_LINES * BLOCK_WORDS));
    ft     = FTAG_W'((int'(addr) % STORE_BYTES) / (FAR_LINES * BLOCK_WORDS));
    if (l1_valid[ni] && l1_tag[ni] == nt) begin
      // L1 hit comes back in natural order
      src   = SRC_L1;
      data  = l1_data[ni];
      first = 0;
    end else begin
      if (l2_valid[fi] && l2_tag[fi] == ft) begin
        src  = SRC_L2;
        data = l2_data[fi];
      end else begin
        src = SRC_MEM;
        for (int k = 0; k < BLOCK_WORDS; k++)
          data[k] = store[(blk_no * BLOCK_WORDS + k) % STORE_BYTES];
        l2_data[fi]  = data;
        l2_valid[fi] = 1'b1;
        l2_tag[fi]   = ft;
      end
      l1_data[ni]  = data;
      l1_valid[ni] = 1'b1;
      l1_tag[ni]   = nt;
    end
    // fills go critical word first, then wrap around
    for (int k = 0; k < BLOCK_WORDS; k++) begin
      w                = (first + k) % BLOCK_WORDS;
      beat.word        = data[w];
      beat.word_offset = OFF_W'(w);
      beat.source      = src;
      beat.last        = (k == BLOCK_WORDS - 1);
      read_beats_q.push_back(beat);
    end
  endtask

  // Compare one returned beat with the oldest prediction
  task automatic check_beat(input res_t got);
    res_t want;
    if (read_beats_q.size() == 0) begin
      errors_o++;
      $display("%0t: unexpected beat, expected none, got word=%02h off=%0d src=%0d last=%0b",
               $time, got.word, got.word_offset, got.source, got.last);
    end else begin
      want = read_beats_q.pop_front();
      checked_o++;
      if (got.word !== want.word) begin
        errors_o++;
        $display("%0t: word mismatch, expected %02h, got %02h", $time, want.word, got.word);
      end
      if (got.word_offset !== want.word_offset) begin
        errors_o++;
        $display("%0t: word_offset mismatch, expected %0d, got %0d",
                 $time, want.word_offset, got.word_offset);
      end
      if (got.source !== want.source) begin
        errors_o++;
        $display("%0t: source mismatch, expected %0d, got %0d",
                 $time, want.source, got.source);
      end
      if (got.last !== want.last) begin
        errors_o++;
        $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, got.last);
      end
    end
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_valid = '0;
      l2_valid = '0;
      for (int i = 0; i < NEAR_LINES; i++) l1_tag[i] = '0;
      for (int i = 0; i < FAR_LINES; i++) l2_tag[i] = '0;
      read_beats_q.delete();
      errors_o  = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_beat(out_data_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.func == FUNC_LOAD)
          store[int'(in_data_i.address) % STORE_BYTES] = in_data_i.load_value;
        else
          predict_read(in_data_i.address);
      end
      pending_o = read_beats_q.size();
    end
  end

endmodule

[dv/tb_two_level_cache_critical_word_first.sv]
`timescale 1ns / 100ps

module tb_two_level_cache_critical_word_first;
  import tlc_pkg::*;

  localparam int BLOCKS = STORE_BYTES / BLOCK_WORDS;

  logic clk       = 1'b0;
  logic rst_n     = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;

  int errors;
  int pending;
  int checked;

  bit loaded [STORE_BYTES];  // store bytes written so far
  int last_blk  = -1;
  int n_loads   = 0;
  int n_reads   = 0;
  bit calm      = 1'b0;      // no idling on either side
  int long_hold = 0;         // cycles of forced output hold-off
  int rx_hold   = 0;

  always #5 clk = ~clk;

  two_level_cache_critical_word_first dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tlc_read_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Output side: random stalls, mostly short, some long, plus forced hold-offs
  always begin
    int r;
    @(posedge clk);
    r = $urandom_range(0, 99);
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold--;
    end else if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else if (calm || r < 70) begin
      out_stall <= 1'b0;
    end else if (r < 95) begin
      out_stall <= 1'b1;
      rx_hold = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b1;
      rx_hold = $urandom_range(10, 40);
    end
  end

  // Offer one beat after a random gap and return at the edge that takes it
  task automatic send(input func_e f, input logic [ADDR_W-1:0] a,
                      input logic [DATA_W-1:0] v);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) gap = 0;
    else if (r < 92)    gap = $urandom_range(1, 3);
    else                gap = $urandom_range(6, 24);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: f, address: a, load_value: v};
    // stall is stable between the falling edge and the next rising edge
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (f == FUNC_LOAD) begin
      loaded[a] = 1'b1;
      n_loads++;
    end else begin
      n_reads++;
    end
  endtask

  function automatic bit block_loaded(input int b);
    for (int k = 0; k < BLOCK_WORDS; k++)
      if (!loaded[b * BLOCK_WORDS + k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic fill_block(input int b);
    for (int k = 0; k < BLOCK_WORDS; k++)
      send(FUNC_LOAD, ADDR_W'(b * BLOCK_WORDS + k), DATA_W'($urandom_range(0, 255)));
  endtask

  // Read a fully loaded block, often the last one to provoke L1 hits
  task automatic read_some_block();
    int b;
    int tries;
    if (last_blk >= 0 && $urandom_range(0, 1) == 1) begin
      b = last_blk;
    end else begin
      b     = $urandom_range(0, BLOCKS - 1);
      tries = 0;
      while (!block_loaded(b) && tries < 64) begin
        b = $urandom_range(0, BLOCKS - 1);
        tries++;
      end
    end
    if (!block_loaded(b)) fill_block(b);
    send(FUNC_READ, ADDR_W'(b * BLOCK_WORDS + $urandom_range(0, BLOCK_WORDS - 1)),
         DATA_W'($urandom_range(0, 255)));
    last_blk = b;
  endtask

  // Hold the sender until every predicted beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int  r;
    bit  pressed;
    bit  paused;
    rst_n   <= 1'b0;
    pressed = 1'b0;
    paused  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme bytes and addresses, each hit kind, stale data
    send(FUNC_LOAD, 7'd0,   8'h00);
    send(FUNC_LOAD, 7'd1,   8'hFF);
    send(FUNC_LOAD, 7'd2,   8'hA5);
    send(FUNC_LOAD, 7'd3,   8'h5A);
    send(FUNC_LOAD, 7'd16,  8'h11);
    send(FUNC_LOAD, 7'd17,  8'h22);
    send(FUNC_LOAD, 7'd18,  8'h33);
    send(FUNC_LOAD, 7'd19,  8'h44);
    send(FUNC_LOAD, 7'd124, 8'h80);
    send(FUNC_LOAD, 7'd125, 8'h7F);
    send(FUNC_LOAD, 7'd126, 8'h01);
    send(FUNC_LOAD, 7'd127, 8'hFE);
    send(FUNC_READ, 7'd1,   8'h00);  // miss in both, wraps from word 1
    send(FUNC_READ, 7'd2,   8'hFF);  // L1 hit, natural order
    send(FUNC_READ, 7'd127, 8'h00);  // top address, last word first
    send(FUNC_READ, 7'd16,  8'h00);  // evicts L1 line 0, L2 keeps block 0
    send(FUNC_READ, 7'd3,   8'h00);  // L2 hit refills L1
    send(FUNC_LOAD, 7'd3,   8'h3C);  // store changes behind the caches
    send(FUNC_READ, 7'd0,   8'h00);  // L1 hit must return the old byte
    drain();

    // Random: block fills, stray loads and reads of loaded blocks
    while (n_loads + n_reads < 320) begin
      if (!pressed && n_loads + n_reads >= 120) begin
        long_hold = 150;
        pressed   = 1'b1;
      end
      if (!paused && n_loads + n_reads >= 200) begin
        drain();
        paused = 1'b1;
      end
      calm = (n_loads + n_reads >= 260 && n_loads + n_reads < 300);
      r = $urandom_range(0, 99);
      if (r < 15)
        fill_block($urandom_range(0, BLOCKS - 1));
      else if (r < 27)
        send(FUNC_LOAD, ADDR_W'($urandom_range(0, STORE_BYTES - 1)),
             DATA_W'($urandom_range(0, 255)));
      else
        read_some_block();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d store loads and %0d cache reads, %0d result beats checked,",
             n_loads, n_reads, checked);
    $display("with a long output hold-off and a full drain in mid-run.");
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/tlc_pkg.sv
rtl/tlc_ctrl.sv
rtl/tlc_dpath.sv
rtl/two_level_cache_critical_word_first.sv
dv/tlc_read_checker.sv
dv/tb_two_level_cache_critical_word_first.sv
